// File: hw/rtl/sefr_pkg.sv
// package for the sync escape frame receiver
// holds the framing byte codes, event codes and default sizes
// no dependencies
`timescale 1ns / 1ps

package sefr_pkg;

    localparam int BUFFER_BYTES_DEF = 128;
    localparam int POS_W            = 9;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] ESC_BYTE  = 8'hFD;
    localparam logic [7:0] UNSET_LEN = 8'hFF;

    typedef enum logic [2:0] {
        EV_SYNC  = 3'd0,
        EV_ESC   = 3'd1,
        EV_CMD   = 3'd2,
        EV_LEN   = 3'd3,
        EV_STORE = 3'd4,
        EV_DROP  = 3'd5,
        EV_OK    = 3'd6,
        EV_BAD   = 3'd7
    } t_event;

endpackage

// File: hw/rtl/sync_escape_frame_receiver.sv
// top level of the sync escape frame receiver
// decodes a byte-stuffed frame stream and reports one event per received byte
// depends on sefr_pkg
`timescale 1ns / 1ps

// One received byte in, one event out, at a sustained rate of one byte per
// clock. The decode of a byte (sync and escape compare, unescape increment,
// checksum add, position compare) is done in the cycle it is taken, and the
// event is loaded into an output register at that cycle's end. A byte is taken whenever
// that register is empty or its event is being taken in the same cycle, so
// the only thing that holds the input back is a stalled output. 0xFF always
// resynchronizes; 0xFD makes the next byte count as its value plus one.
// Payload bytes are not kept: each one is reported with its buffer position,
// and bytes past BUFFER_BYTES are reported as dropped.
module sync_escape_frame_receiver #(
    parameter int BUFFER_BYTES = sefr_pkg::BUFFER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_byte_value,
    output logic [7:0] o_byte_index,
    output logic [7:0] o_frame_command,
    output logic [7:0] o_frame_length
);

    localparam int POS_W = sefr_pkg::POS_W;
    localparam logic [POS_W-1:0] BUF_LIMIT = POS_W'(BUFFER_BYTES);
    localparam logic [POS_W-1:0] LEN_POS   = POS_W'(3);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic             r_esc, n_esc;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_len, n_len;

    logic             r_out_valid;
    sefr_pkg::t_event r_event, n_event;
    logic [7:0]       r_value, n_value;
    logic [7:0]       r_index, n_index;

    logic             w_accept;
    logic [7:0]       w_byte;
    logic [POS_W-1:0] w_pos_inc;

    assign o_rx_ready = !r_out_valid || i_res_ready;
    assign w_accept   = i_rx_valid && o_rx_ready;

    always_comb begin
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_esc     = r_esc;
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_value   = 8'd0;
        n_index   = 8'd0;
        n_event   = sefr_pkg::EV_SYNC;
        w_byte    = r_esc ? i_rx_byte + 8'd1 : i_rx_byte;
        w_pos_inc = r_pos + POS_W'(1);

        if (i_rx_byte == sefr_pkg::SYNC_BYTE) begin
            n_pos   = '0;
            n_cmd   = 8'd0;
            n_len   = sefr_pkg::UNSET_LEN;
            n_sum   = sefr_pkg::SYNC_BYTE;
            n_esc   = 1'b0;
            n_event = sefr_pkg::EV_SYNC;
        end else if (!r_esc && i_rx_byte == sefr_pkg::ESC_BYTE) begin
            n_esc   = 1'b1;
            n_event = sefr_pkg::EV_ESC;
        end else begin
            n_esc   = 1'b0;
            n_value = w_byte;
            n_sum   = r_sum + w_byte;
            if (r_cmd == 8'd0) begin
                n_cmd   = w_byte;
                n_event = sefr_pkg::EV_CMD;
            end else if (r_len == sefr_pkg::UNSET_LEN) begin
                n_len   = w_byte;
                n_pos   = LEN_POS;
                n_event = sefr_pkg::EV_LEN;
            end else if (r_pos >= BUF_LIMIT) begin
                n_event = sefr_pkg::EV_DROP;
            end else begin
                n_index = r_pos[7:0];
                n_pos   = w_pos_inc;
                if (w_pos_inc == {1'b0, r_len} + POS_W'(4)) begin
                    n_event = (n_sum == 8'd0) ? sefr_pkg::EV_OK : sefr_pkg::EV_BAD;
                end else begin
                    n_event = sefr_pkg::EV_STORE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= 8'd0;
            r_esc       <= 1'b0;
            r_cmd       <= 8'd0;
            r_len       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pos       <= n_pos;
                r_sum       <= n_sum;
                r_esc       <= n_esc;
                r_cmd       <= n_cmd;
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on each transfer in
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_event <= n_event;
            r_value <= n_value;
            r_index <= n_index;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_event_res     = r_event;
    assign o_byte_value    = r_value;
    assign o_byte_index    = r_index;
    assign o_frame_command = r_cmd;
    assign o_frame_length  = r_len;

    a_sync_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_rx_byte == sefr_pkg::SYNC_BYTE |=>
            r_pos == '0 && r_sum == sefr_pkg::SYNC_BYTE && !r_esc
            && r_event == sefr_pkg::EV_SYNC)
        else $error("sync did not clear frame state");

    a_escape_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !r_esc && i_rx_byte == sefr_pkg::ESC_BYTE |=>
            r_esc && r_event == sefr_pkg::EV_ESC)
        else $error("escape marker not recorded");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= BUF_LIMIT)
        else $error("write position beyond buffer");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_rx_ready)
        else $error("input stalled with empty output");

    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_pos) && $stable(r_sum) && $stable(r_cmd))
        else $error("frame state moved without a transfer");

endmodule

// File: test/sync_escape_frame_receiver_tb.sv
// self-checking testbench for sync_escape_frame_receiver: directed byte table, then random frames
// predicts untyped events from its own frame decoder, takes typed rows' events from the table,
// checks each result transfer in order; depends on sefr_pkg and the receiver rtl
`timescale 1ns / 1ps

module sync_escape_frame_receiver_tb;

    localparam int BUF_BYTES   = sefr_pkg::BUFFER_BYTES_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 310;

    typedef struct packed {
        sefr_pkg::t_event ev;
        logic [7:0]       val;
        logic [7:0]       idx;
        logic [7:0]       cmd;
        logic [7:0]       len;
    } t_frame_event;

    typedef struct packed {
        logic [7:0]   raw;
        logic         typed;
        t_frame_event want;
    } t_stim_row;

    localparam t_frame_event NO_WANT = '0;

    // typed rows carry the event read straight off the frame rules
    localparam t_stim_row DIRECTED_ROWS [24] = '{
        '{8'h00, 1'b1, '{sefr_pkg::EV_CMD,  8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h05, 1'b1, '{sefr_pkg::EV_CMD,  8'h05, 8'h00, 8'h05, 8'h00}},
        '{8'h10, 1'b0, NO_WANT},
        '{8'h20, 1'b0, NO_WANT},
        '{8'h30, 1'b0, NO_WANT},
        '{8'h40, 1'b0, NO_WANT},
        '{8'hFF, 1'b1, '{sefr_pkg::EV_SYNC, 8'h00, 8'h00, 8'h00, 8'hFF}},
        '{8'hFD, 1'b1, '{sefr_pkg::EV_ESC,  8'h00, 8'h00, 8'h00, 8'hFF}},
        '{8'hFF, 1'b1, '{sefr_pkg::EV_SYNC, 8'h00, 8'h00, 8'h00, 8'hFF}},
        '{8'h00, 1'b1, '{sefr_pkg::EV_CMD,  8'h00, 8'h00, 8'h00, 8'hFF}},
        '{8'hFD, 1'b1, '{sefr_pkg::EV_ESC,  8'h00, 8'h00, 8'h00, 8'hFF}},
        '{8'hFE, 1'b1, '{sefr_pkg::EV_CMD,  8'hFF, 8'h00, 8'hFF, 8'hFF}},
        '{8'hFD, 1'b1, '{sefr_pkg::EV_ESC,  8'h00, 8'h00, 8'hFF, 8'hFF}},
        '{8'hFE, 1'b1, '{sefr_pkg::EV_LEN,  8'hFF, 8'h00, 8'hFF, 8'hFF}},
        '{8'h01, 1'b0, NO_WANT},
        '{8'hFD, 1'b0, NO_WANT},
        '{8'hFC, 1'b0, NO_WANT},
        '{8'h05, 1'b0, NO_WANT},
        '{8'hFD, 1'b0, NO_WANT},
        '{8'hFD, 1'b0, NO_WANT},
        '{8'hFF, 1'b1, '{sefr_pkg::EV_SYNC, 8'h00, 8'h00, 8'h00, 8'hFF}},
        '{8'h7F, 1'b0, NO_WANT},
        '{8'h00, 1'b0, NO_WANT},
        '{8'h00, 1'b1, '{sefr_pkg::EV_BAD,  8'h00, 8'h03, 8'h7F, 8'h00}}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_rx_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_res_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_res_valid;
    logic [2:0] o_event_res;
    logic [7:0] o_byte_value;
    logic [7:0] o_byte_index;
    logic [7:0] o_frame_command;
    logic [7:0] o_frame_length;

    // decoder state
    logic [8:0] dec_pos = '0;
    logic [7:0] dec_sum = '0;
    logic       dec_esc = 1'b0;
    logic [7:0] dec_cmd = '0;
    logic [7:0] dec_len = '0;

    t_frame_event expected_events[$];
    int rx_idle_pct   = 0;
    int res_stall_pct = 0;
    int bytes_sent    = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    sync_escape_frame_receiver #(
        .BUFFER_BYTES(BUF_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_event_res    (o_event_res),
        .o_byte_value   (o_byte_value),
        .o_byte_index   (o_byte_index),
        .o_frame_command(o_frame_command),
        .o_frame_length (o_frame_length)
    );

    function automatic t_frame_event decode_rx_byte(input logic [7:0] raw);
        t_frame_event r;
        logic [7:0]   c;
        r = '0;
        c = raw;
        if (c == sefr_pkg::SYNC_BYTE) begin
            dec_pos = '0;
            dec_cmd = '0;
            dec_len = sefr_pkg::UNSET_LEN;
            dec_sum = sefr_pkg::SYNC_BYTE;
            dec_esc = 1'b0;
            r.ev    = sefr_pkg::EV_SYNC;
        end else if (!dec_esc && c == sefr_pkg::ESC_BYTE) begin
            dec_esc = 1'b1;
            r.ev    = sefr_pkg::EV_ESC;
        end else begin
            if (dec_esc) begin
                dec_esc = 1'b0;
                c       = c + 8'd1;
            end
            r.val   = c;
            dec_sum = dec_sum + c;
            if (dec_cmd == 8'h00) begin
                dec_cmd = c;
                r.ev    = sefr_pkg::EV_CMD;
            end else if (dec_len == sefr_pkg::UNSET_LEN) begin
                dec_len = c;
                dec_pos = 9'd3;
                r.ev    = sefr_pkg::EV_LEN;
            end else if (dec_pos >= BUF_BYTES) begin
                r.ev = sefr_pkg::EV_DROP;
            end else begin
                r.idx   = dec_pos[7:0];
                dec_pos = dec_pos + 9'd1;
                if (dec_pos == {1'b0, dec_len} + 9'd4) begin
                    r.ev = (dec_sum == 8'h00) ? sefr_pkg::EV_OK : sefr_pkg::EV_BAD;
                end else begin
                    r.ev = sefr_pkg::EV_STORE;
                end
            end
        end
        r.cmd = dec_cmd;
        r.len = dec_len;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] raw, input logic typed,
                             input t_frame_event typed_want);
        t_frame_event pred;
        while ($urandom_range(99) < rx_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= raw;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        pred = decode_rx_byte(raw);
        expected_events.push_back(typed ? typed_want : pred);
        bytes_sent++;
    endtask

    // stuffs reserved values and, now and then, any nonzero value
    task automatic send_value(input logic [7:0] v);
        if (v == sefr_pkg::SYNC_BYTE || v == sefr_pkg::ESC_BYTE ||
            (v != 8'h00 && $urandom_range(9) == 0)) begin
            send_byte(sefr_pkg::ESC_BYTE, 1'b0, NO_WANT);
            send_byte(v - 8'd1, 1'b0, NO_WANT);
        end else begin
            send_byte(v, 1'b0, NO_WANT);
        end
    endtask

    task automatic send_frame();
        int         n_pay;
        int         k;
        logic [7:0] cmd_v;
        logic [7:0] len_v;
        logic [7:0] v;
        logic [7:0] sum;
        send_byte(sefr_pkg::SYNC_BYTE, 1'b0, NO_WANT);
        sum = sefr_pkg::SYNC_BYTE;
        if ($urandom_range(19) == 0) send_value(8'h00);
        cmd_v = 8'($urandom_range(255, 1));
        send_value(cmd_v);
        sum = sum + cmd_v;
        if ($urandom_range(29) == 0) begin
            send_value(sefr_pkg::UNSET_LEN);
            sum = sum + sefr_pkg::UNSET_LEN;
        end
        if ($urandom_range(99) < 96) len_v = 8'($urandom_range(12));
        else len_v = 8'($urandom_range(130, 120));
        send_value(len_v);
        sum = sum + len_v;
        n_pay = int'(len_v) + 1;
        if ($urandom_range(9) == 0) n_pay = $urandom_range(n_pay);
        for (k = 0; k < n_pay; k++) begin
            if (k == int'(len_v) && $urandom_range(3) != 0) v = 8'h00 - sum;
            else v = 8'($urandom);
            send_value(v);
            sum = sum + v;
        end
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 1)) send_value(8'($urandom));
        end
    endtask

    task automatic drain_results();
        i_rx_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stall and in-order check of every transfer
    always @(posedge i_clk) begin
        t_frame_event want;
        t_frame_event got;
        i_res_ready <= ($urandom_range(99) >= res_stall_pct);
        if (i_rst_n && o_res_valid && i_res_ready) begin
            got = '{sefr_pkg::t_event'(o_event_res), o_byte_value, o_byte_index,
                    o_frame_command, o_frame_length};
            if (expected_events.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: ev %0d val %h idx %h cmd %h len %h",
                             got.ev, got.val, got.idx, got.cmd, got.len);
            end else begin
                want = expected_events.pop_front();
                if (got.ev !== want.ev || got.val !== want.val || got.idx !== want.idx ||
                    got.cmd !== want.cmd || got.len !== want.len) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: exp ev %0d val %h idx %h cmd %h len %h, ",
                                  "got ev %0d val %h idx %h cmd %h len %h"},
                                 want.ev, want.val, want.idx, want.cmd, want.len,
                                 got.ev, got.val, got.idx, got.cmd, got.len);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int p;
        int r;
        int phase_start;
        int idle_set  [4] = '{0, 74, 0, 9};
        int stall_set [4] = '{0, 0, 74, 9};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < 24; r++) begin
            send_byte(DIRECTED_ROWS[r].raw, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end
        drain_results();

        for (p = 0; p < 4; p++) begin
            rx_idle_pct   = idle_set[p];
            res_stall_pct = stall_set[p];
            phase_start   = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(99) < 15) begin
                    repeat ($urandom_range(8, 1)) send_byte(8'($urandom), 1'b0, NO_WANT);
                end else begin
                    send_frame();
                end
            end
            // sender holds off until every outstanding event is back
            drain_results();
        end

        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && expected_events.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
